[rtl/i2crts_pkg.sv]
// Package for the I2C register transaction sequencer.
// Holds the phase type, status codes, request/state/result structs and sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package i2crts_pkg;

    // Sizing constants.
    localparam int REG_ADDR_BYTES_MAX = 4;
    localparam int LENGTH_WIDTH       = 16;
    localparam int S_TDATA_WIDTH      = 88;
    localparam int M_TDATA_WIDTH      = 32;

    // Request kinds carried on s_tuser.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_EVENT = 1'b1;

    // Controller status codes.
    localparam logic [7:0] ST_START_SENT   = 8'h08;
    localparam logic [7:0] ST_RSTART_SENT  = 8'h10;
    localparam logic [7:0] ST_WADDR_ACK    = 8'h18;
    localparam logic [7:0] ST_WADDR_NACK   = 8'h20;
    localparam logic [7:0] ST_DATA_ACK     = 8'h28;
    localparam logic [7:0] ST_DATA_NACK    = 8'h30;
    localparam logic [7:0] ST_RADDR_ACK    = 8'h40;
    localparam logic [7:0] ST_RADDR_NACK   = 8'h48;
    localparam logic [7:0] ST_RX_ACK       = 8'h50;
    localparam logic [7:0] ST_RX_NACK      = 8'h58;

    // Sequencer phase.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START  = 4'd1,
        PH_ADDR   = 4'd2,
        PH_REG    = 4'd3,
        PH_WDATA  = 4'd4,
        PH_RSTART = 4'd5,
        PH_RADDR  = 4'd6,
        PH_RX     = 4'd7
    } phase_t;

    // One input request.
    typedef struct packed {
        logic        func;
        logic [7:0]  dev_addr;
        logic [31:0] reg_addr;
        logic [2:0]  reg_bytes;
        logic        is_read;
        logic [15:0] length;
        logic [7:0]  status;
        logic [7:0]  rx_data;
        logic [7:0]  tx_data;
    } item_t;

    // Transaction state.
    typedef struct packed {
        phase_t                  phase;
        logic [7:0]              device_byte;
        logic [31:0]             register_address;
        logic [2:0]              register_bytes_left;
        logic                    read_mode;
        logic [LENGTH_WIDTH-1:0] bytes_left;
    } state_t;

    // One result request.
    typedef struct packed {
        logic       load_data;
        logic [7:0] tx_byte;
        logic       set_start;
        logic       set_stop;
        logic       clear_int;
        logic       clear_start;
        logic       set_ack;
        logic       clear_ack;
        logic       read_valid;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       failed;
    } result_t;

endpackage

[rtl/i2crts_step.sv]
// Next-state and result logic of the I2C register transaction sequencer.
// Purely combinational; one request in, at most one result out.
// Depends on i2crts_pkg.
`timescale 1ns / 1ps

module i2crts_step (
    input  i2crts_pkg::state_t  state_cur,
    input  i2crts_pkg::item_t   item,
    output i2crts_pkg::state_t  state_nxt,
    output logic                res_valid,
    output i2crts_pkg::result_t res
);

    logic [1:0] reg_idx;
    logic [7:0] reg_byte;
    logic [2:0] rb_clamped;

    // Register address byte selected by the remaining count, most significant first.
    assign reg_idx  = state_cur.register_bytes_left[1:0] - 2'd1;
    assign reg_byte = state_cur.register_address[{reg_idx, 3'b000} +: 8];

    // Clamp the register byte count to one through the maximum.
    always_comb begin
        rb_clamped = item.reg_bytes;
        if (item.reg_bytes == 3'd0) begin
            rb_clamped = 3'd1;
        end else if (item.reg_bytes > 3'(i2crts_pkg::REG_ADDR_BYTES_MAX)) begin
            rb_clamped = 3'(i2crts_pkg::REG_ADDR_BYTES_MAX);
        end
    end

    // Sequencer step.
    always_comb begin
        state_nxt = state_cur;
        res       = '0;
        res_valid = 1'b0;

        if (item.func == i2crts_pkg::FUNC_START) begin
            if (state_cur.phase == i2crts_pkg::PH_IDLE) begin
                state_nxt.device_byte         = {item.dev_addr[7:1], 1'b0};
                state_nxt.register_address    = item.reg_addr;
                state_nxt.register_bytes_left = rb_clamped;
                state_nxt.read_mode           = item.is_read;
                state_nxt.bytes_left          = i2crts_pkg::LENGTH_WIDTH'(item.length);
                state_nxt.phase               = i2crts_pkg::PH_START;
                res.set_start                 = 1'b1;
                res_valid                     = 1'b1;
            end
        end else begin
            case (state_cur.phase)
                i2crts_pkg::PH_START: begin
                    if (item.status == i2crts_pkg::ST_START_SENT) begin
                        res.load_data   = 1'b1;
                        res.tx_byte     = state_cur.device_byte;
                        res.clear_int   = 1'b1;
                        res.clear_start = 1'b1;
                        res_valid       = 1'b1;
                        state_nxt.phase = i2crts_pkg::PH_ADDR;
                    end
                end
                i2crts_pkg::PH_ADDR: begin
                    if (item.status == i2crts_pkg::ST_WADDR_NACK) begin
                        res.set_stop    = 1'b1;
                        res.clear_int   = 1'b1;
                        res.failed      = 1'b1;
                        res_valid       = 1'b1;
                        state_nxt.phase = i2crts_pkg::PH_IDLE;
                    end else if (item.status == i2crts_pkg::ST_WADDR_ACK) begin
                        res.load_data   = 1'b1;
                        res.tx_byte     = reg_byte;
                        res.clear_int   = 1'b1;
                        res_valid       = 1'b1;
                        state_nxt.register_bytes_left = state_cur.register_bytes_left - 3'd1;
                        state_nxt.phase = i2crts_pkg::PH_REG;
                    end
                end
                i2crts_pkg::PH_REG: begin
                    if (item.status == i2crts_pkg::ST_DATA_NACK) begin
                        res.set_stop    = 1'b1;
                        res.clear_int   = 1'b1;
                        res.failed      = 1'b1;
                        res_valid       = 1'b1;
                        state_nxt.phase = i2crts_pkg::PH_IDLE;
                    end else if (item.status == i2crts_pkg::ST_DATA_ACK) begin
                        res_valid = 1'b1;
                        if (state_cur.register_bytes_left != 3'd0) begin
                            res.load_data = 1'b1;
                            res.tx_byte   = reg_byte;
                            res.clear_int = 1'b1;
                            state_nxt.register_bytes_left =
                                state_cur.register_bytes_left - 3'd1;
                        end else if (state_cur.bytes_left == '0) begin
                            // Nothing to transfer after the register address.
                            res.set_stop    = 1'b1;
                            res.clear_int   = 1'b1;
                            res.done_res    = 1'b1;
                            state_nxt.phase = i2crts_pkg::PH_IDLE;
                        end else if (state_cur.read_mode) begin
                            res.set_start   = 1'b1;
                            res.clear_int   = 1'b1;
                            state_nxt.phase = i2crts_pkg::PH_RSTART;
                        end else begin
                            res.load_data        = 1'b1;
                            res.tx_byte          = item.tx_data;
                            res.clear_int        = 1'b1;
                            state_nxt.bytes_left = state_cur.bytes_left -
                                                   i2crts_pkg::LENGTH_WIDTH'(1);
                            state_nxt.phase      = i2crts_pkg::PH_WDATA;
                        end
                    end
                end
                i2crts_pkg::PH_WDATA: begin
                    if (item.status == i2crts_pkg::ST_DATA_NACK) begin
                        res.set_stop    = 1'b1;
                        res.clear_int   = 1'b1;
                        res.failed      = 1'b1;
                        res_valid       = 1'b1;
                        state_nxt.phase = i2crts_pkg::PH_IDLE;
                    end else if (item.status == i2crts_pkg::ST_DATA_ACK) begin
                        res_valid = 1'b1;
                        if (state_cur.bytes_left == '0) begin
                            res.set_stop    = 1'b1;
                            res.clear_int   = 1'b1;
                            res.done_res    = 1'b1;
                            state_nxt.phase = i2crts_pkg::PH_IDLE;
                        end else begin
                            res.load_data        = 1'b1;
                            res.tx_byte          = item.tx_data;
                            res.clear_int        = 1'b1;
                            state_nxt.bytes_left = state_cur.bytes_left -
                                                   i2crts_pkg::LENGTH_WIDTH'(1);
                        end
                    end
                end
                i2crts_pkg::PH_RSTART: begin
                    if (item.status == i2crts_pkg::ST_RSTART_SENT) begin
                        res.load_data   = 1'b1;
                        res.tx_byte     = {state_cur.device_byte[7:1], 1'b1};
                        res.clear_int   = 1'b1;
                        res.clear_start = 1'b1;
                        res_valid       = 1'b1;
                        state_nxt.phase = i2crts_pkg::PH_RADDR;
                    end
                end
                i2crts_pkg::PH_RADDR: begin
                    if (item.status == i2crts_pkg::ST_RADDR_NACK) begin
                        res.set_stop    = 1'b1;
                        res.clear_int   = 1'b1;
                        res.failed      = 1'b1;
                        res_valid       = 1'b1;
                        state_nxt.phase = i2crts_pkg::PH_IDLE;
                    end else if (item.status == i2crts_pkg::ST_RADDR_ACK) begin
                        // A single-byte read NACKs its only byte.
                        if (state_cur.bytes_left <= i2crts_pkg::LENGTH_WIDTH'(1)) begin
                            res.clear_ack = 1'b1;
                        end else begin
                            res.set_ack = 1'b1;
                        end
                        res.clear_int   = 1'b1;
                        res_valid       = 1'b1;
                        state_nxt.phase = i2crts_pkg::PH_RX;
                    end
                end
                i2crts_pkg::PH_RX: begin
                    if (item.status == i2crts_pkg::ST_RX_NACK) begin
                        // Final byte ends the read even if more were expected.
                        res.read_valid       = 1'b1;
                        res.rx_byte          = item.rx_data;
                        res.set_stop         = 1'b1;
                        res.clear_int        = 1'b1;
                        res.done_res         = 1'b1;
                        res_valid            = 1'b1;
                        state_nxt.bytes_left = '0;
                        state_nxt.phase      = i2crts_pkg::PH_IDLE;
                    end else if (item.status == i2crts_pkg::ST_RX_ACK) begin
                        res.read_valid = 1'b1;
                        res.rx_byte    = item.rx_data;
                        res.clear_int  = 1'b1;
                        res_valid      = 1'b1;
                        if (state_cur.bytes_left != '0) begin
                            state_nxt.bytes_left = state_cur.bytes_left -
                                                   i2crts_pkg::LENGTH_WIDTH'(1);
                        end
                        if (state_nxt.bytes_left <= i2crts_pkg::LENGTH_WIDTH'(1)) begin
                            res.clear_ack = 1'b1;
                        end
                    end
                end
                default: begin
                    // Idle: events are ignored.
                end
            endcase
        end
    end

endmodule

[rtl/i2c_register_transaction_sequencer.sv]
// Top level of the I2C register transaction sequencer.
// Input register, transaction state register and output register around i2crts_step.
// Depends on i2crts_pkg and i2crts_step.
//
// Usage:
//   The slave channel (s_*) takes start requests (s_tuser = 0) that latch the device
//   address, register address, register byte count, direction and length, and
//   controller status events (s_tuser = 1) carrying status, rx_data and tx_data.
//   The master channel (m_*) returns at most one command request per input request:
//   controller strobes, the byte to load, a received byte (m_tuser = 1) and the
//   done/failed flags. Requests that cause no command produce nothing on m_*.
//   From acceptance on s_* a request passes the input register, then the step logic
//   into the output register, which drives m_tvalid. Throughput is one request per
//   cycle while the receiver does not stall; the step logic updates the state register
//   in the same cycle it reads it, so consecutive requests need no gap.
//   When the receiver stalls, the output register holds its request; the input
//   register keeps one more request and then s_tready drops until m_tready returns.
//   Reset (aresetn low, synchronous) empties both registers and returns the sequence
//   to idle with all latched transaction fields cleared.
`timescale 1ns / 1ps

module i2c_register_transaction_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: dev_addr[7:0], reg_addr[39:8], reg_bytes[42:40],
    // is_read[43], length[59:44], status[67:60], rx_data[75:68], tx_data[83:76],
    // zero padding[87:84].
    input  logic [i2crts_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    // s_tuser from bit 0: func.
    input  logic        s_tuser,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: load_data[0], tx_byte[8:1], set_start[9], set_stop[10],
    // clear_int[11], clear_start[12], set_ack[13], clear_ack[14], rx_byte[22:15],
    // done_res[23], failed[24], zero padding[31:25].
    output logic [i2crts_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    // m_tuser from bit 0: read_valid.
    output logic        m_tuser
);

    i2crts_pkg::item_t   item_in;
    i2crts_pkg::item_t   item_reg;
    logic                in_valid_reg;
    i2crts_pkg::state_t  state_reg;
    i2crts_pkg::state_t  state_next;
    i2crts_pkg::result_t res;
    logic                res_valid;
    i2crts_pkg::result_t out_reg;
    logic                out_valid_reg;
    logic                out_free;
    logic                fire;

    // Unpack the incoming request.
    assign item_in.func      = s_tuser;
    assign item_in.dev_addr  = s_tdata[7:0];
    assign item_in.reg_addr  = s_tdata[39:8];
    assign item_in.reg_bytes = s_tdata[42:40];
    assign item_in.is_read   = s_tdata[43];
    assign item_in.length    = s_tdata[59:44];
    assign item_in.status    = s_tdata[67:60];
    assign item_in.rx_data   = s_tdata[75:68];
    assign item_in.tx_data   = s_tdata[83:76];

    // Handshake: the held request advances when the output register has room.
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || fire;

    // Step logic.
    i2crts_step u_step (
        .state_cur (state_reg),
        .item      (item_reg),
        .state_nxt (state_next),
        .res_valid (res_valid),
        .res       (res)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready) begin
            item_reg <= item_in;
        end
    end

    // Transaction state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase               <= i2crts_pkg::PH_IDLE;
            state_reg.device_byte         <= '0;
            state_reg.register_address    <= '0;
            state_reg.register_bytes_left <= '0;
            state_reg.read_mode           <= 1'b0;
            state_reg.bytes_left          <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (fire && res_valid) begin
            out_reg <= res;
        end
    end

    // Pack the result.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.read_valid;
    assign m_tdata  = {7'd0, out_reg.failed, out_reg.done_res, out_reg.rx_byte,
                       out_reg.clear_ack, out_reg.set_ack, out_reg.clear_start,
                       out_reg.clear_int, out_reg.set_stop, out_reg.set_start,
                       out_reg.tx_byte, out_reg.load_data};

endmodule

[rtl/i2crts_checker.sv]
// Port-level checker for the I2C register transaction sequencer, with its bind.
// Watches only the top level ports.
// Depends on i2crts_pkg and i2c_register_transaction_sequencer.
`timescale 1ns / 1ps

module i2crts_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [i2crts_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    input logic                                 m_tuser
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result request present right after reset");

    // A stalled result request holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result request changed");

    // A transaction cannot both succeed and fail.
    a_done_xor_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[23] && m_tdata[24]))
        else $error("done and failed raised together");

    // ACK and NACK are never requested together.
    a_ack_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[13] && m_tdata[14]))
        else $error("set_ack and clear_ack raised together");

    // Unused byte fields stay zero.
    a_bytes_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] || m_tdata[8:1] == 8'd0) &&
                     (m_tuser || m_tdata[22:15] == 8'd0))
        else $error("byte field nonzero without its strobe");

endmodule

bind i2c_register_transaction_sequencer i2crts_checker u_i2crts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/tb_top.sv]
// Self-checking testbench for the I2C register transaction sequencer.
// Drives start and status-event requests, predicts each controller command and checks it.
// Depends on i2crts_pkg and i2c_register_transaction_sequencer.
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_REQUESTS = 1150;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 10;
    localparam int HOLD_AT         = 400;
    localparam int HOLD_CYCLES     = 300;
    localparam logic [2:0] REG_BYTES_CAP = 3'(i2crts_pkg::REG_ADDR_BYTES_MAX);
    localparam logic [i2crts_pkg::LENGTH_WIDTH-1:0] LEFT_ONE =
        i2crts_pkg::LENGTH_WIDTH'(1);

    // One row of the directed table; typed rows carry their command written out.
    typedef struct {
        i2crts_pkg::item_t   req;
        bit                  typed;
        bit                  has_cmd;
        i2crts_pkg::result_t cmd;
    } table_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [i2crts_pkg::S_TDATA_WIDTH-1:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [i2crts_pkg::M_TDATA_WIDTH-1:0] m_tdata;
    logic        m_tuser;

    // Predicted transaction state.
    i2crts_pkg::phase_t                  seq_phase = i2crts_pkg::PH_IDLE;
    logic [7:0]                          seq_device = '0;
    logic [31:0]                         seq_register = '0;
    logic [2:0]                          seq_reg_left = '0;
    logic                                seq_read = 1'b0;
    logic [i2crts_pkg::LENGTH_WIDTH-1:0] seq_left = '0;

    i2crts_pkg::result_t pending_commands[$];
    table_row_t          directed_rows[$];
    int                  mismatches = 0;
    int                  burst_left = 0;
    int unsigned         cycle_count = 0;

    i2c_register_transaction_sequencer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Next register address byte, most significant first.
    function automatic logic [7:0] pop_register_byte();
        logic [2:0] pos;
        pos = seq_reg_left - 3'd1;
        seq_reg_left = pos;
        return seq_register[8 * pos[1:0] +: 8];
    endfunction

    // Stop, clear the interrupt and flag the outcome.
    function automatic void close_transaction(inout i2crts_pkg::result_t cmd, input bit ok);
        cmd.set_stop  = 1'b1;
        cmd.clear_int = 1'b1;
        cmd.done_res  = ok;
        cmd.failed    = !ok;
        seq_phase     = i2crts_pkg::PH_IDLE;
    endfunction

    // Works out the command a request causes; returns 0 when it causes none.
    function automatic bit predict_command(input i2crts_pkg::item_t req,
                                           output i2crts_pkg::result_t cmd);
        logic [2:0] rb;
        cmd = '0;
        if (req.func == i2crts_pkg::FUNC_START) begin
            if (seq_phase != i2crts_pkg::PH_IDLE) return 1'b0;
            seq_device   = {req.dev_addr[7:1], 1'b0};
            seq_register = req.reg_addr;
            rb = req.reg_bytes;
            if (rb == 3'd0) rb = 3'd1;
            if (rb > REG_BYTES_CAP) rb = REG_BYTES_CAP;
            seq_reg_left  = rb;
            seq_read      = req.is_read;
            seq_left      = req.length[i2crts_pkg::LENGTH_WIDTH-1:0];
            cmd.set_start = 1'b1;
            seq_phase     = i2crts_pkg::PH_START;
            return 1'b1;
        end
        case (seq_phase)
            i2crts_pkg::PH_START: begin
                if (req.status != i2crts_pkg::ST_START_SENT) return 1'b0;
                cmd.load_data   = 1'b1;
                cmd.tx_byte     = seq_device;
                cmd.clear_int   = 1'b1;
                cmd.clear_start = 1'b1;
                seq_phase       = i2crts_pkg::PH_ADDR;
            end
            i2crts_pkg::PH_ADDR: begin
                if (req.status == i2crts_pkg::ST_WADDR_NACK) begin
                    close_transaction(cmd, 1'b0);
                end else if (req.status != i2crts_pkg::ST_WADDR_ACK) begin
                    return 1'b0;
                end else begin
                    cmd.load_data = 1'b1;
                    cmd.tx_byte   = pop_register_byte();
                    cmd.clear_int = 1'b1;
                    seq_phase     = i2crts_pkg::PH_REG;
                end
            end
            i2crts_pkg::PH_REG: begin
                if (req.status == i2crts_pkg::ST_DATA_NACK) begin
                    close_transaction(cmd, 1'b0);
                end else if (req.status != i2crts_pkg::ST_DATA_ACK) begin
                    return 1'b0;
                end else if (seq_reg_left != 3'd0) begin
                    cmd.load_data = 1'b1;
                    cmd.tx_byte   = pop_register_byte();
                    cmd.clear_int = 1'b1;
                end else if (seq_left == '0) begin
                    close_transaction(cmd, 1'b1);
                end else if (seq_read) begin
                    cmd.set_start = 1'b1;
                    cmd.clear_int = 1'b1;
                    seq_phase     = i2crts_pkg::PH_RSTART;
                end else begin
                    cmd.load_data = 1'b1;
                    cmd.tx_byte   = req.tx_data;
                    cmd.clear_int = 1'b1;
                    seq_left      = seq_left - LEFT_ONE;
                    seq_phase     = i2crts_pkg::PH_WDATA;
                end
            end
            i2crts_pkg::PH_WDATA: begin
                if (req.status == i2crts_pkg::ST_DATA_NACK) begin
                    close_transaction(cmd, 1'b0);
                end else if (req.status != i2crts_pkg::ST_DATA_ACK) begin
                    return 1'b0;
                end else if (seq_left == '0) begin
                    close_transaction(cmd, 1'b1);
                end else begin
                    cmd.load_data = 1'b1;
                    cmd.tx_byte   = req.tx_data;
                    cmd.clear_int = 1'b1;
                    seq_left      = seq_left - LEFT_ONE;
                end
            end
            i2crts_pkg::PH_RSTART: begin
                if (req.status != i2crts_pkg::ST_RSTART_SENT) return 1'b0;
                cmd.load_data   = 1'b1;
                cmd.tx_byte     = seq_device | 8'h01;
                cmd.clear_int   = 1'b1;
                cmd.clear_start = 1'b1;
                seq_phase       = i2crts_pkg::PH_RADDR;
            end
            i2crts_pkg::PH_RADDR: begin
                if (req.status == i2crts_pkg::ST_RADDR_NACK) begin
                    close_transaction(cmd, 1'b0);
                end else if (req.status != i2crts_pkg::ST_RADDR_ACK) begin
                    return 1'b0;
                end else begin
                    // A single remaining byte is answered with NACK right away.
                    if (seq_left <= LEFT_ONE) cmd.clear_ack = 1'b1;
                    else cmd.set_ack = 1'b1;
                    cmd.clear_int = 1'b1;
                    seq_phase     = i2crts_pkg::PH_RX;
                end
            end
            i2crts_pkg::PH_RX: begin
                if (req.status == i2crts_pkg::ST_RX_NACK) begin
                    // The final byte ends the read even if more were expected.
                    cmd.read_valid = 1'b1;
                    cmd.rx_byte    = req.rx_data;
                    seq_left       = '0;
                    close_transaction(cmd, 1'b1);
                end else if (req.status != i2crts_pkg::ST_RX_ACK) begin
                    return 1'b0;
                end else begin
                    cmd.read_valid = 1'b1;
                    cmd.rx_byte    = req.rx_data;
                    cmd.clear_int  = 1'b1;
                    if (seq_left != '0) seq_left = seq_left - LEFT_ONE;
                    if (seq_left <= LEFT_ONE) cmd.clear_ack = 1'b1;
                end
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic i2crts_pkg::item_t start_req(input logic [7:0] dev,
                                                    input logic [31:0] addr,
                                                    input logic [2:0] rb, input logic rd,
                                                    input logic [15:0] len);
        i2crts_pkg::item_t req;
        req = '0;
        req.func      = i2crts_pkg::FUNC_START;
        req.dev_addr  = dev;
        req.reg_addr  = addr;
        req.reg_bytes = rb;
        req.is_read   = rd;
        req.length    = len;
        return req;
    endfunction

    function automatic i2crts_pkg::item_t event_req(input logic [7:0] st,
                                                    input logic [7:0] rx,
                                                    input logic [7:0] tx);
        i2crts_pkg::item_t req;
        req = '0;
        req.func    = i2crts_pkg::FUNC_EVENT;
        req.status  = st;
        req.rx_data = rx;
        req.tx_data = tx;
        return req;
    endfunction

    function automatic void add_row(input i2crts_pkg::item_t req, input bit typed,
                                    input bit has_cmd, input i2crts_pkg::result_t cmd);
        table_row_t row;
        row.req     = req;
        row.typed   = typed;
        row.has_cmd = has_cmd;
        row.cmd     = cmd;
        directed_rows.push_back(row);
    endfunction

    // Random request shaped by the predicted phase: mostly the awaited status,
    // some NACKs, some noise and some starts while busy.
    function automatic i2crts_pkg::item_t random_request();
        i2crts_pkg::item_t req;
        logic [31:0]       r0, r1, r2, pick;
        int                roll, nack_pct;
        logic [7:0]        ack_code, nack_code;
        r0 = $urandom;
        r1 = $urandom;
        r2 = $urandom;
        req.func      = i2crts_pkg::FUNC_EVENT;
        req.dev_addr  = r0[7:0];
        req.status    = r0[15:8];
        req.rx_data   = r0[23:16];
        req.tx_data   = r0[31:24];
        req.reg_addr  = r1;
        req.reg_bytes = r2[2:0];
        req.is_read   = r2[3];
        roll = $urandom_range(99);
        if (roll < 70) pick = $urandom_range(5);
        else if (roll < 90) pick = $urandom_range(40, 6);
        else pick = {16'h0, r2[31:16]};
        req.length = pick[15:0];

        roll = $urandom_range(99);
        if (seq_phase == i2crts_pkg::PH_IDLE) begin
            if (roll < 90) req.func = i2crts_pkg::FUNC_START;
            return req;
        end
        if (roll < 4) begin
            req.func = i2crts_pkg::FUNC_START;
            return req;
        end
        if (roll < 8) return req;

        nack_pct = 4;
        case (seq_phase)
            i2crts_pkg::PH_START: begin
                ack_code  = i2crts_pkg::ST_START_SENT;
                nack_code = i2crts_pkg::ST_START_SENT;
            end
            i2crts_pkg::PH_ADDR: begin
                ack_code  = i2crts_pkg::ST_WADDR_ACK;
                nack_code = i2crts_pkg::ST_WADDR_NACK;
            end
            i2crts_pkg::PH_REG: begin
                ack_code  = i2crts_pkg::ST_DATA_ACK;
                nack_code = i2crts_pkg::ST_DATA_NACK;
            end
            i2crts_pkg::PH_WDATA: begin
                ack_code  = i2crts_pkg::ST_DATA_ACK;
                nack_code = i2crts_pkg::ST_DATA_NACK;
            end
            i2crts_pkg::PH_RSTART: begin
                ack_code  = i2crts_pkg::ST_RSTART_SENT;
                nack_code = i2crts_pkg::ST_RSTART_SENT;
            end
            i2crts_pkg::PH_RADDR: begin
                ack_code  = i2crts_pkg::ST_RADDR_ACK;
                nack_code = i2crts_pkg::ST_RADDR_NACK;
            end
            default: begin
                // In the receive phase the off case is the early final byte, or
                // an extra acknowledged byte once the count has run out.
                if (seq_left <= LEFT_ONE) begin
                    ack_code  = i2crts_pkg::ST_RX_NACK;
                    nack_code = i2crts_pkg::ST_RX_ACK;
                    nack_pct  = 12;
                end else begin
                    ack_code  = i2crts_pkg::ST_RX_ACK;
                    nack_code = i2crts_pkg::ST_RX_NACK;
                end
            end
        endcase
        // Long transfers are cut short more often to keep the run bounded.
        if ((seq_phase == i2crts_pkg::PH_WDATA || seq_phase == i2crts_pkg::PH_RX) &&
            seq_left > i2crts_pkg::LENGTH_WIDTH'(40)) nack_pct = 12;
        req.status = (roll < 8 + nack_pct) ? nack_code : ack_code;
        return req;
    endfunction

    // Offers one request in bursts with random gaps and records what it should cause.
    task automatic offer_request(input i2crts_pkg::item_t req, input bit typed,
                                 input bit typed_has, input i2crts_pkg::result_t typed_cmd,
                                 output bit caused);
        int                  gap;
        i2crts_pkg::result_t cmd;
        if (burst_left == 0) begin
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(24, 1);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.func;
        s_tdata  <= {4'b0, req.tx_data, req.rx_data, req.status, req.length, req.is_read,
                     req.reg_bytes, req.reg_addr, req.dev_addr};
        do @(posedge aclk); while (s_tready !== 1'b1);
        burst_left--;
        caused = predict_command(req, cmd);
        if (typed) begin
            if (typed_has) pending_commands.push_back(typed_cmd);
        end else if (caused) begin
            pending_commands.push_back(cmd);
        end
    endtask

    function automatic void report_field(input string name, input logic [7:0] exp_v,
                                         input logic [7:0] got_v);
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
        mismatches++;
    endfunction

    task automatic compare_command(input i2crts_pkg::result_t exp,
                                   input i2crts_pkg::result_t got);
        if (got.load_data !== exp.load_data)
            report_field("load_data", 8'(exp.load_data), 8'(got.load_data));
        if (got.tx_byte !== exp.tx_byte) report_field("tx_byte", exp.tx_byte, got.tx_byte);
        if (got.set_start !== exp.set_start)
            report_field("set_start", 8'(exp.set_start), 8'(got.set_start));
        if (got.set_stop !== exp.set_stop)
            report_field("set_stop", 8'(exp.set_stop), 8'(got.set_stop));
        if (got.clear_int !== exp.clear_int)
            report_field("clear_int", 8'(exp.clear_int), 8'(got.clear_int));
        if (got.clear_start !== exp.clear_start)
            report_field("clear_start", 8'(exp.clear_start), 8'(got.clear_start));
        if (got.set_ack !== exp.set_ack)
            report_field("set_ack", 8'(exp.set_ack), 8'(got.set_ack));
        if (got.clear_ack !== exp.clear_ack)
            report_field("clear_ack", 8'(exp.clear_ack), 8'(got.clear_ack));
        if (got.read_valid !== exp.read_valid)
            report_field("read_valid", 8'(exp.read_valid), 8'(got.read_valid));
        if (got.rx_byte !== exp.rx_byte) report_field("rx_byte", exp.rx_byte, got.rx_byte);
        if (got.done_res !== exp.done_res)
            report_field("done_res", 8'(exp.done_res), 8'(got.done_res));
        if (got.failed !== exp.failed)
            report_field("failed", 8'(exp.failed), 8'(got.failed));
    endtask

    // Each accepted command request is checked against the oldest prediction.
    always @(posedge aclk) begin : command_monitor
        i2crts_pkg::result_t got;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got.load_data   = m_tdata[0];
            got.tx_byte     = m_tdata[8:1];
            got.set_start   = m_tdata[9];
            got.set_stop    = m_tdata[10];
            got.clear_int   = m_tdata[11];
            got.clear_start = m_tdata[12];
            got.set_ack     = m_tdata[13];
            got.clear_ack   = m_tdata[14];
            got.rx_byte     = m_tdata[22:15];
            got.done_res    = m_tdata[23];
            got.failed      = m_tdata[24];
            got.read_valid  = m_tuser;
            if (pending_commands.size() == 0) begin
                $error("command request with none predicted: m_tdata %h", m_tdata);
                mismatches++;
            end else begin
                compare_command(pending_commands.pop_front(), got);
            end
        end
    end

    // Receiver: segments of random stall patterns and one long hold-off.
    initial begin : command_sink
        int          tick, seg_left, mode;
        bit          held;
        logic [31:0] coin;
        tick = 0;
        seg_left = 0;
        mode = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            tick++;
            if (!held && tick == HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                held = 1'b1;
            end
            if (seg_left == 0) begin
                mode = $urandom_range(2);
                seg_left = $urandom_range(150, 10);
            end
            seg_left--;
            coin = $urandom;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= coin[0];
                default: m_tready <= (tick % 6) >= 2;
            endcase
        end
    end

    // Directed table, then random requests, then drain and verdict.
    initial begin : stimulus
        i2crts_pkg::result_t cmd;
        bit                  caused;
        int                  sent;
        int                  drain;

        // Event while idle is ignored.
        add_row(event_req(i2crts_pkg::ST_START_SENT, 8'h00, 8'h00), 1'b1, 1'b0, '0);
        // Zero-length write, register byte count zero taken as one.
        cmd = '0;
        cmd.set_start = 1'b1;
        add_row(start_req(8'hFF, 32'hA1B2C3D4, 3'd0, 1'b0, 16'd0), 1'b1, 1'b1, cmd);
        cmd = '0;
        cmd.load_data   = 1'b1;
        cmd.tx_byte     = 8'hFE;
        cmd.clear_int   = 1'b1;
        cmd.clear_start = 1'b1;
        add_row(event_req(i2crts_pkg::ST_START_SENT, 8'h00, 8'hFF), 1'b1, 1'b1, cmd);
        // Start while busy and a status not awaited are both ignored.
        add_row(start_req(8'h12, 32'h0, 3'd1, 1'b1, 16'd3), 1'b1, 1'b0, '0);
        add_row(event_req(8'h99, 8'hFF, 8'hFF), 1'b1, 1'b0, '0);
        add_row(event_req(i2crts_pkg::ST_WADDR_ACK, 8'h00, 8'h00), 1'b0, 1'b0, '0);
        cmd = '0;
        cmd.set_stop  = 1'b1;
        cmd.clear_int = 1'b1;
        cmd.done_res  = 1'b1;
        add_row(event_req(i2crts_pkg::ST_DATA_ACK, 8'h00, 8'hFF), 1'b1, 1'b1, cmd);
        // Zero-length read, register byte count above the cap taken as four.
        add_row(start_req(8'h00, 32'hFFFFFFFF, 3'd7, 1'b1, 16'd0), 1'b0, 1'b0, '0);
        add_row(event_req(i2crts_pkg::ST_START_SENT, 8'h00, 8'h00), 1'b0, 1'b0, '0);
        add_row(event_req(i2crts_pkg::ST_WADDR_ACK, 8'h00, 8'h00), 1'b0, 1'b0, '0);
        repeat (3)
            add_row(event_req(i2crts_pkg::ST_DATA_ACK, 8'h00, 8'h00), 1'b0, 1'b0, '0);
        add_row(event_req(i2crts_pkg::ST_DATA_ACK, 8'h00, 8'h00), 1'b1, 1'b1, cmd);
        // Address NACK aborts.
        add_row(start_req(8'h55, 32'h0, 3'd2, 1'b1, 16'd1), 1'b0, 1'b0, '0);
        add_row(event_req(i2crts_pkg::ST_START_SENT, 8'h00, 8'h00), 1'b0, 1'b0, '0);
        cmd = '0;
        cmd.set_stop  = 1'b1;
        cmd.clear_int = 1'b1;
        cmd.failed    = 1'b1;
        add_row(event_req(i2crts_pkg::ST_WADDR_NACK, 8'h00, 8'h00), 1'b1, 1'b1, cmd);
        // Single-byte read: repeated start, read address, NACKed only byte.
        add_row(start_req(8'h3C, 32'h12, 3'd1, 1'b1, 16'd1), 1'b0, 1'b0, '0);
        add_row(event_req(i2crts_pkg::ST_START_SENT, 8'h00, 8'h00), 1'b0, 1'b0, '0);
        add_row(event_req(i2crts_pkg::ST_WADDR_ACK, 8'h00, 8'h00), 1'b0, 1'b0, '0);
        add_row(event_req(i2crts_pkg::ST_DATA_ACK, 8'h00, 8'h00), 1'b0, 1'b0, '0);
        add_row(event_req(i2crts_pkg::ST_RSTART_SENT, 8'h00, 8'h00), 1'b0, 1'b0, '0);
        add_row(event_req(i2crts_pkg::ST_RADDR_ACK, 8'h00, 8'h00), 1'b0, 1'b0, '0);
        add_row(event_req(i2crts_pkg::ST_RX_NACK, 8'hFF, 8'h00), 1'b0, 1'b0, '0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            offer_request(directed_rows[i].req, directed_rows[i].typed,
                          directed_rows[i].has_cmd, directed_rows[i].cmd, caused);

        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            offer_request(random_request(), 1'b0, 1'b0, '0, caused);
            sent++;
        end
        s_tvalid <= 1'b0;

        drain = 0;
        while (pending_commands.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_commands.size() != 0) begin
            $error("%0d predicted commands never arrived", pending_commands.size());
            mismatches++;
        end
        if (mismatches == 0) $display("tb_top: clean");
        else $display("tb_top: errors");
        $finish;
    end

endmodule
